[design/stok_pkg.sv]
// Package for the source tokenizer: token kinds, error kinds, scan phases,
// keyword table and character class helpers. No dependencies.
package stok_pkg;

   localparam int CounterBitsDefault = 24;
   localparam int OutBits = 24;
   localparam int NumKw = 14;
   localparam int MaxResults = 3;

   typedef enum logic [5:0] {
      TK_IDENT = 6'd0, TK_MENTRE = 6'd1, TK_MAIN = 6'd2, TK_VERO = 6'd3,
      TK_FALSO = 6'd4, TK_FUN = 6'd5, TK_SIA = 6'd6, TK_SE = 6'd7,
      TK_STAMPA = 6'd8, TK_ALTRIMENTI = 6'd9, TK_EE = 6'd10, TK_OO = 6'd11,
      TK_RITORNA = 6'd12, TK_NULLA = 6'd13, TK_NON = 6'd14,
      TK_ERROR = 6'd15, TK_STRING = 6'd16, TK_NUMBER = 6'd17, TK_EOF = 6'd18,
      TK_LPAREN = 6'd19, TK_RPAREN = 6'd20, TK_LBRACE = 6'd21,
      TK_RBRACE = 6'd22, TK_SEMI = 6'd23, TK_COMMA = 6'd24, TK_DOT = 6'd25,
      TK_PLUS = 6'd26, TK_MINUS = 6'd27, TK_STAR = 6'd28, TK_SLASH = 6'd29,
      TK_BANGBANG = 6'd30, TK_NE = 6'd31, TK_EQEQ = 6'd32, TK_EQ = 6'd33,
      TK_LE = 6'd34, TK_LT = 6'd35, TK_GE = 6'd36, TK_GT = 6'd37
   } kind_type;

   typedef enum logic [1:0] {
      ERR_NONE = 2'd0, ERR_UNEXPECTED = 2'd1, ERR_UNTERMINATED = 2'd2
   } err_type;

   typedef enum logic [3:0] {
      PH_IDLE, PH_SLASH, PH_LCOMM, PH_BCOMM, PH_BSTAR, PH_IDENT, PH_NUM,
      PH_NUMDOT, PH_FRAC, PH_STR, PH_BANG, PH_EQ, PH_LT, PH_GT
   } phase_type;

   // one emitted token; start and length are already clamped to OutBits
   typedef struct packed {
      kind_type kind;
      err_type  err;
      logic [OutBits-1:0] start;
      logic [OutBits-1:0] len;
   } tok_type;

   localparam logic [3:0] KwLen [NumKw] = '{
      4'd6, 4'd4, 4'd4, 4'd5, 4'd3, 4'd3, 4'd2, 4'd6, 4'd10, 4'd2, 4'd2,
      4'd7, 4'd5, 4'd3};

   function automatic logic [7:0] kw_char(input int k, input logic [3:0] idx);
      logic [8*10-1:0] s;
      case (k)
         0: s = "mentre";
         1: s = "main";
         2: s = "vero";
         3: s = "falso";
         4: s = "fun";
         5: s = "sia";
         6: s = "se";
         7: s = "stampa";
         8: s = "altrimenti";
         9: s = "ee";
         10: s = "oo";
         11: s = "ritorna";
         12: s = "nulla";
         default: s = "non";
      endcase
      // strings are right-aligned; char idx sits at byte len-1-idx
      if (idx >= KwLen[k]) kw_char = 8'h00;
      else kw_char = s[8*(KwLen[k] - 4'd1 - idx) +: 8];
   endfunction

   function automatic logic [NumKw-1:0] mask_update(input logic [NumKw-1:0] m,
         input logic [3:0] idx, input logic [7:0] c);
      logic [NumKw-1:0] r;
      r = m;
      for (int k = 0; k < NumKw; k++)
         if (idx >= KwLen[k] || kw_char(k, idx) != c) r[k] = 1'b0;
      mask_update = r;
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      is_digit = (c >= "0" && c <= "9");
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      is_alpha = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
   endfunction

endpackage

[design/source_tokenizer_unit.sv]
// Source tokenizer: one byte per transaction in, up to three tokens out.
// A top-level module only; uses stok_pkg.
//
// Accepts one byte or end marker per cycle while the queue has room. A
// transaction is scanned in the cycle after acceptance from the input
// register; its tokens (up to three) are written into a result queue at
// the end of that cycle, and they leave one per cycle while rsp_ready is high.
// Input is taken whenever the queue has room for six more tokens: three for
// the transaction still in the input register and three for the new one.
// So the rate is one byte per cycle as long as bytes average at most one
// token each and rsp_ready stays high; a byte that yields two or three tokens
// takes an output slot for each. Line, offset and length saturate at 2^24-1; counters at
// 2^COUNTER_BITS-1.
module source_tokenizer_unit
   import stok_pkg::*;
#(
   parameter int COUNTER_BITS = CounterBitsDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_ch,
   input  logic        req_is_end,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [5:0]  rsp_token_kind,
   output logic [1:0]  rsp_error_kind,
   output logic [23:0] rsp_line_number,
   output logic [23:0] rsp_start_offset,
   output logic [23:0] rsp_token_length,
   output logic        rsp_last
);

   localparam int CB = COUNTER_BITS;
   localparam logic [CB-1:0] CMax = '1;
   localparam int QDepth = 8;
   localparam int QW = $clog2(QDepth);

   typedef struct packed {
      tok_type tok;
      logic [OutBits-1:0] line;
      logic last;
   } qent_type;

   // input register
   logic       iv_ff, iv_in;
   logic [7:0] ich_ff;
   logic       iend_ff;

   // scanner state
   phase_type       phase_ff, phase_in;
   logic [CB-1:0]   line_ff, line_in, pos_ff, pos_in, tstart_ff, tstart_in;
   logic [CB-1:0]   dot_ff, dot_in;
   logic [NumKw-1:0] kw_ff, kw_in;

   // result queue
   qent_type     q_mem [QDepth];
   logic [QW-1:0] wp_ff, rp_ff;
   logic [QW:0]   cnt_ff, cnt_in;

   tok_type t0, t1, t2;
   logic [1:0] n;
   logic [CB-1:0] line_emit;
   logic [CB-1:0] line_fresh;

   function automatic logic [OutBits-1:0] clampo(input logic [CB-1:0] v);
      if (CB > OutBits && (v >> OutBits) != '0) clampo = '1;
      else clampo = OutBits'(v);
   endfunction

   function automatic logic [CB-1:0] sinc(input logic [CB-1:0] v);
      sinc = (v == CMax) ? v : v + 1'b1;
   endfunction

   function automatic tok_type mk(input kind_type k, input err_type e,
         input logic [CB-1:0] s, input logic [CB-1:0] l);
      tok_type t;
      t.kind = k; t.err = e; t.start = clampo(s); t.len = clampo(l);
      mk = t;
   endfunction

   function automatic kind_type ident_kind(input logic [NumKw-1:0] m,
         input logic [CB-1:0] len);
      kind_type r;
      r = TK_IDENT;
      for (int k = NumKw - 1; k >= 0; k--)
         if (m[k] && len == CB'(KwLen[k])) r = kind_type'(6'(k + 1));
      ident_kind = r;
   endfunction

   function automatic kind_type single_kind(input logic [7:0] c);
      case (c)
         "(": single_kind = TK_LPAREN;
         ")": single_kind = TK_RPAREN;
         "{": single_kind = TK_LBRACE;
         "}": single_kind = TK_RBRACE;
         ";": single_kind = TK_SEMI;
         ",": single_kind = TK_COMMA;
         ".": single_kind = TK_DOT;
         "+": single_kind = TK_PLUS;
         "-": single_kind = TK_MINUS;
         "*": single_kind = TK_STAR;
         default: single_kind = TK_ERROR;
      endcase
   endfunction

   assign req_ready = (cnt_ff <= (QW+1)'(QDepth - 2*MaxResults));
   assign iv_in = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) iv_ff <= 1'b0;
      else iv_ff <= iv_in;
      if (iv_in) begin
         ich_ff <= req_ch;
         iend_ff <= req_is_end;
      end
   end

   // scanner
   always_comb begin
      logic [7:0] c;
      logic again, fr_tok;
      logic [CB-1:0] pos, len;
      logic [3:0] idx;
      tok_type ft;
      c = ich_ff;
      pos = pos_ff;
      len = pos_ff - tstart_ff;
      idx = (len > CB'(15)) ? 4'd15 : len[3:0];
      phase_in = phase_ff;
      line_in = line_ff;
      pos_in = pos_ff;
      tstart_in = tstart_ff;
      dot_in = dot_ff;
      kw_in = kw_ff;
      t0 = mk(TK_EOF, ERR_NONE, pos, '0);
      t1 = t0;
      t2 = t0;
      n = 2'd0;
      again = 1'b0;
      line_emit = line_ff;
      line_fresh = line_ff;
      fr_tok = 1'b0;
      ft = t0;
      if (iv_ff && iend_ff) begin
         n = 2'd1;
         case (phase_ff)
            PH_SLASH: begin t0 = mk(TK_SLASH, ERR_NONE, tstart_ff, CB'(1)); n = 2'd2; end
            PH_IDENT: begin t0 = mk(ident_kind(kw_ff, len), ERR_NONE, tstart_ff, len); n = 2'd2; end
            PH_NUM, PH_FRAC: begin t0 = mk(TK_NUMBER, ERR_NONE, tstart_ff, len); n = 2'd2; end
            PH_NUMDOT: begin
               t0 = mk(TK_NUMBER, ERR_NONE, tstart_ff, dot_ff - tstart_ff);
               t1 = mk(TK_DOT, ERR_NONE, dot_ff, CB'(1));
               n = 2'd3;
            end
            PH_STR: begin t0 = mk(TK_ERROR, ERR_UNTERMINATED, tstart_ff, len); n = 2'd2; end
            PH_BANG: begin t0 = mk(TK_ERROR, ERR_UNEXPECTED, tstart_ff, CB'(1)); n = 2'd2; end
            PH_EQ: begin t0 = mk(TK_EQ, ERR_NONE, tstart_ff, CB'(1)); n = 2'd2; end
            PH_LT: begin t0 = mk(TK_LT, ERR_NONE, tstart_ff, CB'(1)); n = 2'd2; end
            PH_GT: begin t0 = mk(TK_GT, ERR_NONE, tstart_ff, CB'(1)); n = 2'd2; end
            default: ;
         endcase
         if (n == 2'd2) t1 = mk(TK_EOF, ERR_NONE, pos, '0);
         if (n == 2'd3) t2 = mk(TK_EOF, ERR_NONE, pos, '0);
         phase_in = PH_IDLE;
         line_in = CB'(1);
         pos_in = '0;
         tstart_in = '0;
         kw_in = '0;
         dot_in = '0;
      end else if (iv_ff) begin
         case (phase_ff)
            PH_SLASH:
               if (c == "/") phase_in = PH_LCOMM;
               else if (c == "*") phase_in = PH_BCOMM;
               else begin t0 = mk(TK_SLASH, ERR_NONE, tstart_ff, CB'(1)); n = 2'd1; again = 1'b1; end
            PH_LCOMM:
               if (c == 8'h0a) begin line_in = sinc(line_ff); phase_in = PH_IDLE; end
            PH_BCOMM, PH_BSTAR:
               if (phase_ff == PH_BSTAR && c == "/") phase_in = PH_IDLE;
               else if (c == "*") phase_in = PH_BSTAR;
               else begin
                  if (c == 8'h0a) line_in = sinc(line_ff);
                  phase_in = PH_BCOMM;
               end
            PH_IDENT:
               if (is_alpha(c) || is_digit(c)) kw_in = mask_update(kw_ff, idx, c);
               else begin
                  t0 = mk(ident_kind(kw_ff, len), ERR_NONE, tstart_ff, len);
                  n = 2'd1; again = 1'b1;
               end
            PH_NUM:
               if (is_digit(c)) ;
               else if (c == ".") begin phase_in = PH_NUMDOT; dot_in = pos; end
               else begin t0 = mk(TK_NUMBER, ERR_NONE, tstart_ff, len); n = 2'd1; again = 1'b1; end
            PH_NUMDOT:
               if (is_digit(c)) phase_in = PH_FRAC;
               else begin
                  t0 = mk(TK_NUMBER, ERR_NONE, tstart_ff, dot_ff - tstart_ff);
                  t1 = mk(TK_DOT, ERR_NONE, dot_ff, CB'(1));
                  n = 2'd2; again = 1'b1;
               end
            PH_FRAC:
               if (!is_digit(c)) begin
                  t0 = mk(TK_NUMBER, ERR_NONE, tstart_ff, len); n = 2'd1; again = 1'b1;
               end
            PH_STR:
               if (c == "\"") begin
                  t0 = mk(TK_STRING, ERR_NONE, tstart_ff, sinc(pos) - tstart_ff);
                  n = 2'd1; phase_in = PH_IDLE;
               end else if (c == 8'h0a) line_in = sinc(line_ff);
            PH_BANG:
               if (c == "!") begin
                  t0 = mk(TK_BANGBANG, ERR_NONE, tstart_ff, CB'(2)); n = 2'd1; phase_in = PH_IDLE;
               end else if (c == "=") begin
                  t0 = mk(TK_NE, ERR_NONE, tstart_ff, CB'(2)); n = 2'd1; phase_in = PH_IDLE;
               end else begin
                  t0 = mk(TK_ERROR, ERR_UNEXPECTED, tstart_ff, CB'(1)); n = 2'd1; again = 1'b1;
               end
            PH_EQ, PH_LT, PH_GT:
               if (c == "=") begin
                  t0 = mk((phase_ff == PH_EQ) ? TK_EQEQ : (phase_ff == PH_LT) ? TK_LE : TK_GE,
                          ERR_NONE, tstart_ff, CB'(2));
                  n = 2'd1; phase_in = PH_IDLE;
               end else begin
                  t0 = mk((phase_ff == PH_EQ) ? TK_EQ : (phase_ff == PH_LT) ? TK_LT : TK_GT,
                          ERR_NONE, tstart_ff, CB'(1));
                  n = 2'd1; again = 1'b1;
               end
            default: again = 1'b1;
         endcase
         if (again) begin
            phase_in = PH_IDLE;
            tstart_in = pos;
            if (c == " " || c == 8'h0d || c == 8'h09) ;
            else if (c == 8'h0a) begin line_in = sinc(line_ff); line_fresh = line_in; end
            else if (is_digit(c)) phase_in = PH_NUM;
            else if (is_alpha(c)) begin
               phase_in = PH_IDENT;
               kw_in = mask_update('1, 4'd0, c);
            end else if (c == "/") phase_in = PH_SLASH;
            else if (c == "\"") phase_in = PH_STR;
            else if (c == "!") phase_in = PH_BANG;
            else if (c == "=") phase_in = PH_EQ;
            else if (c == "<") phase_in = PH_LT;
            else if (c == ">") phase_in = PH_GT;
            else begin
               fr_tok = 1'b1;
               if (single_kind(c) == TK_ERROR) ft = mk(TK_ERROR, ERR_UNEXPECTED, pos, CB'(1));
               else ft = mk(single_kind(c), ERR_NONE, pos, CB'(1));
            end
         end
         if (fr_tok) begin
            case (n)
               2'd0: t0 = ft;
               2'd1: t1 = ft;
               default: t2 = ft;
            endcase
            n = n + 2'd1;
         end
         pos_in = sinc(pos);
      end
      // all tokens of a byte carry the line before it; a newline that ends
      // a token is counted only after that token
      line_emit = line_ff;
      if (line_fresh != line_ff) line_emit = line_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         line_ff <= CB'(1);
         pos_ff <= '0;
         tstart_ff <= '0;
         kw_ff <= '0;
         dot_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         line_ff <= line_in;
         pos_ff <= pos_in;
         tstart_ff <= tstart_in;
         kw_ff <= kw_in;
         dot_ff <= dot_in;
      end
   end

   // result queue
   logic pop;
   assign pop = rsp_valid && rsp_ready;
   assign cnt_in = cnt_ff + (QW+1)'(n) - (QW+1)'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff <= wp_ff + QW'(n);
         rp_ff <= rp_ff + QW'(pop);
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (n != 2'd0) q_mem[wp_ff] <= '{tok: t0, line: clampo(line_emit), last: n == 2'd1};
      if (n >= 2'd2) q_mem[wp_ff + QW'(1)] <= '{tok: t1, line: clampo(line_emit),
                                                last: n == 2'd2};
      if (n == 2'd3) q_mem[wp_ff + QW'(2)] <= '{tok: t2, line: clampo(line_emit), last: 1'b1};
   end

   qent_type head;
   assign head = q_mem[rp_ff];
   assign rsp_valid = (cnt_ff != '0);
   assign rsp_token_kind = head.tok.kind;
   assign rsp_error_kind = head.tok.err;
   assign rsp_line_number = head.line;
   assign rsp_start_offset = head.tok.start;
   assign rsp_token_length = head.tok.len;
   assign rsp_last = head.last;

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= (QW+1)'(QDepth))
      else $error("result queue overflow");
   a_ready_room: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> cnt_ff <= (QW+1)'(QDepth - 2*MaxResults))
      else $error("ready without room");
   a_end_resets: assert property (@(posedge clock) disable iff (reset)
      (iv_ff && iend_ff) |=> (phase_ff == PH_IDLE && pos_ff == '0))
      else $error("end marker did not reset scanner");
   a_end_emits: assert property (@(posedge clock) disable iff (reset)
      (iv_ff && iend_ff) |-> n != 2'd0)
      else $error("end marker without EOF");

endmodule

[tb/sv/stok_checker.sv]
// Token stream checker for source_tokenizer_unit: watches both channels,
// predicts tokens with its own scanner model and compares. Uses stok_pkg.
module stok_checker
   import stok_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [7:0]  req_ch,
   input  logic        req_is_end,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [5:0]  rsp_token_kind,
   input  logic [1:0]  rsp_error_kind,
   input  logic [23:0] rsp_line_number,
   input  logic [23:0] rsp_start_offset,
   input  logic [23:0] rsp_token_length,
   input  logic        rsp_last,
   output int          fail_count,
   output int          tokens_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      kind_type    kind;
      err_type     err;
      logic [23:0] line;
      logic [23:0] start;
      logic [23:0] len;
      logic        last;
   } token_type;

   localparam logic [23:0] Sat = 24'hFFFFFF;
   localparam string KwWord [NumKw] = '{"mentre", "main", "vero", "falso", "fun",
      "sia", "se", "stampa", "altrimenti", "ee", "oo", "ritorna", "nulla", "non"};

   token_type   token_q[$];
   token_type   step_toks[$];
   phase_type   ph;
   logic [23:0] line_cnt, pos, tstart, dot_off;
   logic [13:0] cand;

   function automatic logic [23:0] sinc(logic [23:0] v);
      return (v == Sat) ? Sat : v + 24'd1;
   endfunction

   function automatic bit digit_c(logic [7:0] c);
      return c >= 8'h30 && c <= 8'h39;
   endfunction

   function automatic bit alpha_c(logic [7:0] c);
      return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) || c == 8'h5f;
   endfunction

   function automatic logic [13:0] narrow(logic [13:0] m, int idx, logic [7:0] c);
      for (int k = 0; k < NumKw; k++)
         if (m[k] && (idx >= KwWord[k].len() || KwWord[k][idx] != c)) m[k] = 1'b0;
      return m;
   endfunction

   function automatic kind_type word_kind(logic [23:0] n);
      for (int k = 0; k < NumKw; k++)
         if (cand[k] && n == KwWord[k].len()) return kind_type'(k + 1);
      return TK_IDENT;
   endfunction

   task automatic emit(kind_type k, err_type e, logic [23:0] s, logic [23:0] n);
      token_type t;
      t.kind = k; t.err = e; t.line = line_cnt; t.start = s; t.len = n; t.last = 0;
      if (step_toks.size() < MaxResults) step_toks.push_back(t);
   endtask

   task automatic scan_fresh(logic [7:0] c, logic [23:0] p);
      ph = PH_IDLE;
      tstart = p;
      case (c)
         8'h20, 8'h0d, 8'h09: ;
         8'h0a: line_cnt = sinc(line_cnt);
         8'h2f: ph = PH_SLASH;
         8'h22: ph = PH_STR;
         8'h21: ph = PH_BANG;
         8'h3d: ph = PH_EQ;
         8'h3c: ph = PH_LT;
         8'h3e: ph = PH_GT;
         8'h28: emit(TK_LPAREN, ERR_NONE, p, 1);
         8'h29: emit(TK_RPAREN, ERR_NONE, p, 1);
         8'h7b: emit(TK_LBRACE, ERR_NONE, p, 1);
         8'h7d: emit(TK_RBRACE, ERR_NONE, p, 1);
         8'h3b: emit(TK_SEMI, ERR_NONE, p, 1);
         8'h2c: emit(TK_COMMA, ERR_NONE, p, 1);
         8'h2e: emit(TK_DOT, ERR_NONE, p, 1);
         8'h2b: emit(TK_PLUS, ERR_NONE, p, 1);
         8'h2d: emit(TK_MINUS, ERR_NONE, p, 1);
         8'h2a: emit(TK_STAR, ERR_NONE, p, 1);
         default:
            if (digit_c(c)) ph = PH_NUM;
            else if (alpha_c(c)) begin
               ph = PH_IDENT;
               cand = narrow(14'h3FFF, 0, c);
            end else emit(TK_ERROR, ERR_UNEXPECTED, p, 1);
      endcase
   endtask

   task automatic clear_state();
      ph = PH_IDLE; line_cnt = 1; pos = 0; tstart = 0; cand = 0; dot_off = 0;
   endtask

   task automatic predict_tokens(logic [7:0] c, logic isend);
      logic [23:0] p;
      bit again;
      int idx;
      p = pos;
      again = 0;
      step_toks.delete();
      if (isend) begin
         case (ph)
            PH_SLASH: emit(TK_SLASH, ERR_NONE, tstart, 1);
            PH_IDENT: emit(word_kind(p - tstart), ERR_NONE, tstart, p - tstart);
            PH_NUM, PH_FRAC: emit(TK_NUMBER, ERR_NONE, tstart, p - tstart);
            PH_NUMDOT: begin
               emit(TK_NUMBER, ERR_NONE, tstart, dot_off - tstart);
               emit(TK_DOT, ERR_NONE, dot_off, 1);
            end
            PH_STR: emit(TK_ERROR, ERR_UNTERMINATED, tstart, p - tstart);
            PH_BANG: emit(TK_ERROR, ERR_UNEXPECTED, tstart, 1);
            PH_EQ: emit(TK_EQ, ERR_NONE, tstart, 1);
            PH_LT: emit(TK_LT, ERR_NONE, tstart, 1);
            PH_GT: emit(TK_GT, ERR_NONE, tstart, 1);
            default: ;
         endcase
         emit(TK_EOF, ERR_NONE, p, 0);
         clear_state();
      end else begin
         case (ph)
            PH_SLASH:
               if (c == 8'h2f) ph = PH_LCOMM;
               else if (c == 8'h2a) ph = PH_BCOMM;
               else begin emit(TK_SLASH, ERR_NONE, tstart, 1); again = 1; end
            PH_LCOMM:
               if (c == 8'h0a) begin line_cnt = sinc(line_cnt); ph = PH_IDLE; end
            PH_BCOMM, PH_BSTAR:
               if (ph == PH_BSTAR && c == 8'h2f) ph = PH_IDLE;
               else if (c == 8'h2a) ph = PH_BSTAR;
               else begin
                  if (c == 8'h0a) line_cnt = sinc(line_cnt);
                  ph = PH_BCOMM;
               end
            PH_IDENT:
               if (alpha_c(c) || digit_c(c)) begin
                  idx = (p - tstart > 15) ? 15 : int'(p - tstart);
                  cand = narrow(cand, idx, c);
               end else begin
                  emit(word_kind(p - tstart), ERR_NONE, tstart, p - tstart);
                  again = 1;
               end
            PH_NUM:
               if (c == 8'h2e) begin ph = PH_NUMDOT; dot_off = p; end
               else if (!digit_c(c)) begin
                  emit(TK_NUMBER, ERR_NONE, tstart, p - tstart);
                  again = 1;
               end
            PH_NUMDOT:
               if (digit_c(c)) ph = PH_FRAC;
               else begin
                  emit(TK_NUMBER, ERR_NONE, tstart, dot_off - tstart);
                  emit(TK_DOT, ERR_NONE, dot_off, 1);
                  again = 1;
               end
            PH_FRAC:
               if (!digit_c(c)) begin
                  emit(TK_NUMBER, ERR_NONE, tstart, p - tstart);
                  again = 1;
               end
            PH_STR:
               if (c == 8'h22) begin
                  emit(TK_STRING, ERR_NONE, tstart, sinc(p) - tstart);
                  ph = PH_IDLE;
               end else if (c == 8'h0a) line_cnt = sinc(line_cnt);
            PH_BANG:
               if (c == 8'h21) begin emit(TK_BANGBANG, ERR_NONE, tstart, 2); ph = PH_IDLE; end
               else if (c == 8'h3d) begin emit(TK_NE, ERR_NONE, tstart, 2); ph = PH_IDLE; end
               else begin emit(TK_ERROR, ERR_UNEXPECTED, tstart, 1); again = 1; end
            PH_EQ, PH_LT, PH_GT:
               if (c == 8'h3d) begin
                  emit(ph == PH_EQ ? TK_EQEQ : ph == PH_LT ? TK_LE : TK_GE,
                     ERR_NONE, tstart, 2);
                  ph = PH_IDLE;
               end else begin
                  emit(ph == PH_EQ ? TK_EQ : ph == PH_LT ? TK_LT : TK_GT,
                     ERR_NONE, tstart, 1);
                  again = 1;
               end
            default: again = 1;
         endcase
         if (again) scan_fresh(c, p);
         pos = sinc(p);
      end
      if (step_toks.size() > 0) step_toks[step_toks.size() - 1].last = 1;
      foreach (step_toks[i]) token_q.push_back(step_toks[i]);
   endtask

   task automatic report_mismatch(string what);
      $display("%0t: token mismatch: %s", $time, what);
      fail_count++;
   endtask

   always @(posedge clock) begin
      token_type want;
      if (reset) begin
         clear_state();
         token_q.delete();
         fail_count = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (token_q.size() == 0)
               report_mismatch($sformatf("unexpected token kind %0d", rsp_token_kind));
            else begin
               want = token_q.pop_front();
               if (rsp_token_kind !== want.kind || rsp_error_kind !== want.err ||
                     rsp_line_number !== want.line || rsp_start_offset !== want.start ||
                     rsp_token_length !== want.len || rsp_last !== want.last)
                  report_mismatch($sformatf(
                     "got k%0d e%0d ln%0d at%0d len%0d l%0b, want k%0d e%0d ln%0d at%0d len%0d l%0b",
                     rsp_token_kind, rsp_error_kind, rsp_line_number, rsp_start_offset,
                     rsp_token_length, rsp_last, want.kind, want.err, want.line,
                     want.start, want.len, want.last));
            end
         end
         if (req_valid && req_ready) predict_tokens(req_ch, req_is_end);
      end
      tokens_pending = token_q.size();
   end
endmodule

[tb/sv/testbench.sv]
// Top of the source tokenizer testbench: clock, reset, byte stimulus and
// verdict. Depends on stok_pkg, source_tokenizer_unit and stok_checker.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   logic        clock = 0, reset = 1;
   logic        req_valid = 0, req_ready, req_is_end = 0;
   logic [7:0]  req_ch = 0;
   logic        rsp_valid, rsp_ready = 0, rsp_last;
   logic [5:0]  rsp_token_kind;
   logic [1:0]  rsp_error_kind;
   logic [23:0] rsp_line_number, rsp_start_offset, rsp_token_length;
   int          fail_count, tokens_pending;
   int          hold_cycles = 0;
   int          sent = 0;

   source_tokenizer_unit u_dut (.*);
   stok_checker u_check (.*);

   initial forever #5 clock = ~clock;

   // receiver: stall pattern, with long hold-offs on request
   initial begin
      @(negedge clock);
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            rsp_ready <= 0;
            hold_cycles--;
         end else rsp_ready <= ($urandom_range(0, 3) != 0) || sent > 200;
      end
   end

   task automatic send_byte(logic [7:0] c, logic e);
      req_valid <= 1; req_ch <= c; req_is_end <= e;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      sent++;
      if ($urandom_range(0, 5) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
   endtask

   task automatic send_text(string s);
      foreach (s[i]) send_byte(s[i], 1'b0);
   endtask

   task automatic send_end();
      send_byte(8'($urandom), 1'b1);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (tokens_pending != 0) @(negedge clock);
   endtask

   function automatic string random_piece();
      string w [] = '{"mentre", "main", "vero", "falso", "fun", "sia", "se", "stampa",
         "altrimenti", "ee", "oo", "ritorna", "nulla", "non", "mero", "fia", "x_9",
         "12.5", "7.", "3.x", "\"ab\ncd\"", "// hi\n", "/* a*b\n**/", "!!", "!=",
         "!a", "==", "<=", ">=", "<", ">", "=", "(){};,.+-*/", " \t\r\n", "42"};
      return w[$urandom_range(0, w.size() - 1)];
   endfunction

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      // directed: keywords, operators, special cases
      send_text("mentre mero fia altrimenti\n");
      send_text("1.2 3.x 4.;!!!=! a==<=<>=>");
      send_byte(8'h00, 1'b0); send_byte(8'hFF, 1'b0); send_byte(8'h0b, 1'b0);
      send_text("/*c*/ // z\n\"s");
      send_end();
      send_text("5.");
      send_end();
      drain();
      // long receiver hold-off while bytes keep coming
      hold_cycles = 60;
      send_text("(((((((((((((((((((((((((((((");
      drain();
      while (sent < 350) begin
         if ($urandom_range(0, 9) == 0) send_byte(8'($urandom), 1'b0);
         else send_text(random_piece());
         if ($urandom_range(0, 15) == 0) send_end();
         if ($urandom_range(0, 30) == 0) drain();
      end
      send_text("\"open");
      send_end();
      drain();
      repeat (20) @(negedge clock);
      if (fail_count == 0 && tokens_pending == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      #2ms;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule
